// ----- rtl/gdpc_pkg.sv -----
// ---------------------------------------------------------------------------
// gdpc_pkg: shared types and constants for the GPIO debounce and pulse cell
// Word layouts, command and status codes, timer widths and the pad check.
// ---------------------------------------------------------------------------
package gdpc_pkg;

   // pulse timer width (8..32)
   localparam int PULSE_TIMER_BITS = 16;
   localparam logic [PULSE_TIMER_BITS-1:0] TIMER_MAX = '1;

   localparam int STEADY_BITS = 14;
   localparam logic [STEADY_BITS-1:0] STEADY_MAX = '1;
   localparam logic [STEADY_BITS-1:0] DEBOUNCE_MIN = 14'd5;
   localparam logic [STEADY_BITS-1:0] DEBOUNCE_MAX = 14'd10000;
   localparam logic [STEADY_BITS-1:0] DEBOUNCE_RESET = 14'd100;

   localparam int PIN_BITS = 6;
   localparam int LENGTH_BITS = 16;
   localparam int CSR_DATA_BITS = 14;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_MS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT_ACTIVE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIN_NUMBER = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIN_VALID = 2'd3;

   // commands
   localparam logic [2:0] CMD_NONE = 3'd0;
   localparam logic [2:0] CMD_SET_LEVEL = 3'd1;
   localparam logic [2:0] CMD_START_PULSE = 3'd2;
   localparam logic [2:0] CMD_TO_INPUT = 3'd3;
   localparam logic [2:0] CMD_TO_OUTPUT = 3'd4;

   // status
   localparam logic [2:0] STS_OK = 3'd0;
   localparam logic [2:0] STS_NOT_INIT = 3'd1;
   localparam logic [2:0] STS_PULSE_BUSY = 3'd2;
   localparam logic [2:0] STS_UNSAFE_PIN = 3'd3;
   localparam logic [2:0] STS_IGNORED = 3'd4;

   typedef struct packed {
      logic                   pad_level;
      logic [2:0]             command;
      logic                   drive_level;
      logic [LENGTH_BITS-1:0] pulse_length;
   } req_type;

   typedef struct packed {
      logic       output_enable;
      logic       pad_drive;
      logic       active;
      logic       stable_changed;
      logic       pulse_done;
      logic [2:0] command_status;
   } rsp_type;

   // strapping, flash and input-only pads may not change mode
   function automatic logic pad_is_safe(input logic [PIN_BITS-1:0] p);
      logic ok;
      ok = 1'b1;
      if (p == 6'd0 || p == 6'd2 || p == 6'd15) ok = 1'b0;
      if (p >= 6'd34 && p <= 6'd39) ok = 1'b0;
      if (p >= 6'd6 && p <= 6'd11) ok = 1'b0;
      return ok;
   endfunction

endpackage

// ----- rtl/gpio_debounce_pulse_cell.sv -----
// ---------------------------------------------------------------------------
// gpio_debounce_pulse_cell: GPIO cell with debounced input and one-shot output
// One word per millisecond tick: tick handling first, then the command.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-----------------------------
//  req     | in        | req_valid/req_ready  | pad level, command, drive, length
//  rsp     | out       | rsp_valid/rsp_ready  | mode, drive, active, events, status
//  csr     | in        | csr_we (no wait)     | index + data, no read-back
//
//  Each accepted word is handled at once: the cell state and the result register
//  load on the same edge, so a word may enter every cycle while req_ready is high.
//  The single result register sets the rate; req_ready drops only while a
//  result is held and rsp_ready is low.
//  Reset is synchronous, active high; config returns to its reset values.
//
module gpio_debounce_pulse_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gdpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gdpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [gdpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gdpc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import gdpc_pkg::*;

   // configuration
   logic [STEADY_BITS-1:0] debounce_ff;
   logic                   invert_ff;
   logic [PIN_BITS-1:0]    pin_ff;
   logic                   pin_valid_ff;

   // cell state
   logic                        output_mode_ff, output_mode_in;
   logic                        raw_level_ff, raw_level_in;
   logic                        stable_level_ff, stable_level_in;
   logic [STEADY_BITS-1:0]      steady_ff, steady_in;
   logic                        drive_ff, drive_in;
   logic                        pulse_running_ff, pulse_running_in;
   logic [PULSE_TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [PULSE_TIMER_BITS-1:0] target_ff, target_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic [STEADY_BITS-1:0] debounce_wr;
   logic [32:0] len_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // debounce writes clamp into the legal window
   always_comb begin
      if (csr_wdata < DEBOUNCE_MIN) begin
         debounce_wr = DEBOUNCE_MIN;
      end else if (csr_wdata > DEBOUNCE_MAX) begin
         debounce_wr = DEBOUNCE_MAX;
      end else begin
         debounce_wr = csr_wdata;
      end
   end

   assign len_wide = 33'(req_data.pulse_length);

   always_comb begin
      logic       changed;
      logic       done;
      logic [2:0] status;
      logic       want;
      output_mode_in   = output_mode_ff;
      raw_level_in     = raw_level_ff;
      stable_level_in  = stable_level_ff;
      steady_in        = steady_ff;
      drive_in         = drive_ff;
      pulse_running_in = pulse_running_ff;
      elapsed_in       = elapsed_ff;
      target_in        = target_ff;
      changed          = 1'b0;
      done             = 1'b0;
      status           = STS_OK;
      want             = (req_data.command == CMD_TO_OUTPUT);

      // tick: debouncer, only when sampling in input mode with a valid pin
      if (!output_mode_ff && pin_valid_ff) begin
         if (req_data.pad_level == raw_level_ff) begin
            if (steady_ff != STEADY_MAX) steady_in = steady_ff + STEADY_BITS'(1);
            if (req_data.pad_level != stable_level_ff && steady_in >= debounce_ff) begin
               stable_level_in = req_data.pad_level;
               changed         = 1'b1;
            end
         end else begin
            raw_level_in = req_data.pad_level;
            steady_in    = '0;
         end
      end

      // tick: pulse timer, saturating
      if (pulse_running_ff) begin
         if (elapsed_ff != TIMER_MAX) elapsed_in = elapsed_ff + PULSE_TIMER_BITS'(1);
         if (elapsed_in >= target_ff) begin
            drive_in         = 1'b0;
            pulse_running_in = 1'b0;
            done             = 1'b1;
         end
      end

      // command
      case (req_data.command)
         CMD_NONE: begin
            status = STS_OK;
         end
         CMD_SET_LEVEL, CMD_START_PULSE: begin
            if (!output_mode_ff) begin
               status = STS_IGNORED;
            end else if (!pin_valid_ff) begin
               status = STS_NOT_INIT;
            end else if (req_data.command == CMD_SET_LEVEL) begin
               drive_in = req_data.drive_level;
            end else if (pulse_running_in) begin
               status = STS_PULSE_BUSY;
            end else begin
               drive_in         = 1'b1;
               pulse_running_in = 1'b1;
               elapsed_in       = '0;
               target_in        = (len_wide > 33'(TIMER_MAX)) ? TIMER_MAX
                                  : len_wide[PULSE_TIMER_BITS-1:0];
            end
         end
         CMD_TO_INPUT, CMD_TO_OUTPUT: begin
            if (want == output_mode_ff) begin
               status = STS_OK;
            end else if (!pin_valid_ff) begin
               status = STS_NOT_INIT;
            end else if (pulse_running_in) begin
               status = STS_PULSE_BUSY;
            end else if (!pad_is_safe(pin_ff)) begin
               status = STS_UNSAFE_PIN;
            end else begin
               drive_in         = 1'b0;
               pulse_running_in = 1'b0;
               if (!want) begin
                  raw_level_in    = req_data.pad_level;
                  stable_level_in = req_data.pad_level;
                  steady_in       = '0;
               end
               output_mode_in = want;
            end
         end
         default: begin
            status = STS_IGNORED;
         end
      endcase

      rsp_in.output_enable  = output_mode_in;
      rsp_in.pad_drive      = output_mode_in && drive_in;
      rsp_in.active         = (!stable_level_in) ^ invert_ff;
      rsp_in.stable_changed = changed;
      rsp_in.pulse_done     = done;
      rsp_in.command_status = status;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         invert_ff    <= 1'b0;
         pin_ff       <= '0;
         pin_valid_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:   debounce_ff  <= debounce_wr;
            CSR_INVERT_ACTIVE: invert_ff    <= csr_wdata[0];
            CSR_PIN_NUMBER:    pin_ff       <= csr_wdata[PIN_BITS-1:0];
            CSR_PIN_VALID:     pin_valid_ff <= csr_wdata[0];
            default:           pin_valid_ff <= pin_valid_ff;
         endcase
      end
   end

   // cell state advances once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         output_mode_ff   <= 1'b0;
         raw_level_ff     <= 1'b1;
         stable_level_ff  <= 1'b1;
         steady_ff        <= '0;
         drive_ff         <= 1'b0;
         pulse_running_ff <= 1'b0;
         elapsed_ff       <= '0;
         target_ff        <= '0;
      end else if (accept) begin
         output_mode_ff   <= output_mode_in;
         raw_level_ff     <= raw_level_in;
         stable_level_ff  <= stable_level_in;
         steady_ff        <= steady_in;
         drive_ff         <= drive_in;
         pulse_running_ff <= pulse_running_in;
         elapsed_ff       <= elapsed_in;
         target_ff        <= target_in;
      end
   end

   // result register: loads on accept, frees when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a pulse only runs in output mode
   a_pulse_needs_output: assert property (@(posedge clock) disable iff (reset)
      pulse_running_ff |-> output_mode_ff)
      else $error("pulse running in input mode");

   // the pad is never driven in input mode
   a_no_drive_in_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.output_enable) |-> !rsp_ff.pad_drive)
      else $error("pad driven in input mode");

   // debounce window stays clamped
   a_debounce_window: assert property (@(posedge clock) disable iff (reset)
      (debounce_ff >= DEBOUNCE_MIN) && (debounce_ff <= DEBOUNCE_MAX))
      else $error("debounce time out of range");

   // a held result is not overwritten
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");
`endif

endmodule
